// File: rtl/core/bgcd_pkg.sv
// ----------------------------------------------------------------------------
// bgcd_pkg
// shared types and constants for the signed binary gcd unit
// ----------------------------------------------------------------------------
package bgcd_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } bgcd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } bgcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } bgcd_status_t;

endpackage

// File: rtl/core/bgcd_dp.sv
// ----------------------------------------------------------------------------
// bgcd_dp
// operand registers, one binary gcd step per cycle, result register
// ----------------------------------------------------------------------------
module bgcd_dp #(
    parameter int DATA_WIDTH = bgcd_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bgcd_pkg::bgcd_cmd_t     cmd,
    output bgcd_pkg::bgcd_status_t  status,
    input  logic [DATA_WIDTH-1:0]   first_operand,
    input  logic [DATA_WIDTH-1:0]   second_operand,
    output logic [DATA_WIDTH-1:0]   divisor
);
    import bgcd_pkg::*;

    localparam int SHIFT_WIDTH = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0]  a_reg, a_next;
    logic [DATA_WIDTH-1:0]  b_reg, b_next;
    logic [SHIFT_WIDTH-1:0] k_reg, k_next;
    logic [DATA_WIDTH-1:0]  divisor_reg, divisor_next;
    logic [DATA_WIDTH-1:0]  mag_a;
    logic [DATA_WIDTH-1:0]  mag_b;
    logic                   a_ge_b;
    logic [DATA_WIDTH-1:0]  base;

    // magnitudes; the most negative value maps onto its unsigned magnitude
    assign mag_a = first_operand[DATA_WIDTH-1]  ? (~first_operand + 1'b1)  : first_operand;
    assign mag_b = second_operand[DATA_WIDTH-1] ? (~second_operand + 1'b1) : second_operand;

    assign a_ge_b      = (a_reg >= b_reg);
    assign status.done = (a_reg == '0) || (b_reg == '0) || (a_reg == b_reg);
    assign base        = (a_reg == '0) ? b_reg : a_reg;

    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        divisor_next = divisor_reg;
        if (cmd.load)
        begin
            a_next = mag_a;
            b_next = mag_b;
            k_next = '0;
        end
        else if (cmd.step)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + SHIFT_WIDTH'(1);
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_ge_b)
            begin
                a_next = a_reg - b_reg;
            end
            else
            begin
                b_next = b_reg - a_reg;
            end
        end
        if (cmd.capture)
        begin
            divisor_next = base << k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg       <= '0;
            b_reg       <= '0;
            k_reg       <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            k_reg       <= k_next;
            divisor_reg <= divisor_next;
        end
    end

    assign divisor = divisor_reg;

endmodule

// File: rtl/core/bgcd_ctrl.sv
// ----------------------------------------------------------------------------
// bgcd_ctrl
// handshake and sequencing for the binary gcd datapath
// ----------------------------------------------------------------------------
module bgcd_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bgcd_pkg::bgcd_cmd_t     cmd,
    input  bgcd_pkg::bgcd_status_t  status
);
    import bgcd_pkg::*;

    bgcd_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.capture = 1'b0;
        in_ready    = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.done)
                begin
                    cmd.step = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/binary_gcd_signed_unit.sv
// ----------------------------------------------------------------------------
// binary_gcd_signed_unit
// greatest common divisor of the magnitudes of two signed operands
//
// input channel in_valid/in_ready carries first_operand and second_operand;
// output channel out_valid/out_ready carries divisor, one per input transfer.
// one operand pair is worked on at a time. after the input transfer the
// datapath does one binary gcd step per cycle: halve an even operand, halve
// both while both are even, or subtract the smaller odd one from the larger.
// the loop ends when an operand is zero or both are equal, then the result
// register loads once the output register is free. the number of steps is
// set by the subtract-and-shift loop: every subtract is followed by a halve
// and the halves are bounded by the operand bits. the next pair can transfer
// the cycle after the result loads, so a new pair is taken only after the
// previous one has finished.
// in_ready is high only while no pair is being worked on; the output register
// lets a new pair start while the previous result still waits. if the
// receiver stalls, a finished pair holds in the datapath until the output
// register frees. reset clears the controller, the datapath registers and
// the output valid flag.
// ----------------------------------------------------------------------------
module binary_gcd_signed_unit #(
    parameter int DATA_WIDTH = bgcd_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DATA_WIDTH-1:0]  first_operand,
    input  logic [DATA_WIDTH-1:0]  second_operand,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DATA_WIDTH-1:0]  divisor
);
    import bgcd_pkg::*;

    bgcd_cmd_t    cmd;
    bgcd_status_t status;

    bgcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    bgcd_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .divisor        (divisor)
    );

endmodule
